// ===== rtl/rdma_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rdma_pkg
// Shared types and constants for the region decoded memory access unit.
// ----------------------------------------------------------------------------
package rdma_pkg;

   localparam int NUM_REGIONS  = 4;
   localparam int REGION_BYTES = 4096;
   localparam int REG_COUNT    = 4;

   localparam int ADDR_W   = 32;
   localparam int DATA_W   = 32;
   localparam int SIZE_W   = 13;
   localparam int HIT_W    = 2;
   localparam int CSR_IX_W = 3;

   localparam int OFF_W    = $clog2(REGION_BYTES);
   localparam int BANK_W   = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;
   localparam int LANES    = 4;
   localparam int ROW_W    = OFF_W - 2;
   localparam int LANE_AW  = BANK_W + ROW_W;
   localparam int LANE_DEPTH = (1 << LANE_AW);

   localparam int QDEPTH   = 2;
   localparam int QPTR_W   = 1;
   localparam int QCNT_W   = 2;

   localparam logic [7:0] BYTE_MASK = 8'hff;

   typedef enum logic [2:0] {
      OP_FETCH32  = 3'd0,
      OP_LOAD32   = 3'd1,
      OP_LOAD16   = 3'd2,
      OP_LOAD8    = 3'd3,
      OP_STORE32L = 3'd4,
      OP_STORE32B = 3'd5,
      OP_STORE16  = 3'd6,
      OP_STORE8   = 3'd7
   } op_type;

   typedef struct packed {
      op_type              op;
      logic                unmapped;
      logic [HIT_W-1:0]    hit;
      logic [OFF_W-1:0]    off;
      logic [DATA_W-1:0]   wdata;
   } entry_type;

endpackage
`default_nettype wire

// ===== rtl/rdma_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rdma_front
// Region registers and parallel address decode; builds one queue entry.
// ----------------------------------------------------------------------------
module rdma_front
   import rdma_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IX_W-1:0]  csr_index,
   input  wire logic [DATA_W-1:0]    csr_wdata,
   input  wire op_type               op,
   input  wire logic [ADDR_W-1:0]    address,
   input  wire logic [DATA_W-1:0]    write_data,
   output entry_type                 entry
);

   logic [ADDR_W-1:0] start_ff [REG_COUNT];
   logic [SIZE_W-1:0] size_ff  [REG_COUNT];
   logic [ADDR_W-1:0] diff     [NUM_REGIONS];
   logic              match    [NUM_REGIONS];
   logic              found;
   logic [HIT_W-1:0]  hit;
   logic [OFF_W-1:0]  off;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) begin
            start_ff[i] <= '0;
            size_ff[i]  <= '0;
         end
      end else if (csr_we) begin
         if (csr_index[0]) begin
            size_ff[csr_index[CSR_IX_W-1:1]] <= csr_wdata[SIZE_W-1:0];
         end else begin
            start_ff[csr_index[CSR_IX_W-1:1]] <= csr_wdata;
         end
      end
   end

   for (genvar g = 0; g < NUM_REGIONS; g++) begin : g_cmp
      assign diff[g]  = address - start_ff[g];
      assign match[g] = (address >= start_ff[g]) &&
                        (diff[g] < {{(ADDR_W-SIZE_W){1'b0}}, size_ff[g]});
   end

   // lowest index wins
   always_comb begin
      found = 1'b0;
      hit   = '0;
      off   = '0;
      for (int i = NUM_REGIONS - 1; i >= 0; i--) begin
         if (match[i]) begin
            found = 1'b1;
            hit   = HIT_W'(i);
            off   = diff[i][OFF_W-1:0];
         end
      end
   end

   always_comb begin
      entry.op       = op;
      entry.unmapped = !found;
      entry.hit      = hit;
      entry.off      = off;
      entry.wdata    = write_data;
   end

endmodule
`default_nettype wire

// ===== rtl/rdma_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rdma_queue
// Two-entry FIFO between the decode front and the memory back end.
// ----------------------------------------------------------------------------
module rdma_queue
   import rdma_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire entry_type  push_entry,
   output logic            not_full,
   input  wire logic       pop,
   output logic            not_empty,
   output entry_type       head
);

   entry_type          slot_ff [QDEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   assign not_full  = (count_ff != QCNT_W'(QDEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/rdma_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rdma_back
// Byte-lane banked memory, access stage and result register.
// ----------------------------------------------------------------------------
module rdma_back
   import rdma_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_not_empty,
   input  wire entry_type          q_head,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [DATA_W-1:0]       rsp_read_data,
   output logic                    rsp_unmapped,
   output logic [HIT_W-1:0]        rsp_hit
);

   logic              is_store;
   logic [2:0]        nbytes;
   logic [7:0]        wbyte   [LANES];
   logic [7:0]        lane_rd [LANES];
   logic [7:0]        rbyte   [LANES];
   logic [BANK_W-1:0] bank;

   logic              exec_valid_ff, exec_valid_in;
   op_type            exec_op_ff;
   logic              exec_unm_ff;
   logic [HIT_W-1:0]  exec_hit_ff;
   logic [1:0]        exec_sh_ff;
   logic              exec_adv;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_unm_ff;
   logic [HIT_W-1:0]  rsp_hit_ff;
   logic              out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign exec_adv = exec_valid_ff && out_free;
   assign q_pop    = q_not_empty && (!exec_valid_ff || exec_adv);
   assign bank     = q_head.hit[BANK_W-1:0];

   // byte k of the access, k counted from the lowest address
   always_comb begin
      is_store = 1'b0;
      nbytes   = 3'd4;
      for (int k = 0; k < LANES; k++) begin
         wbyte[k] = q_head.wdata[8*k +: 8];
      end
      case (q_head.op)
         OP_STORE32L: begin
            is_store = 1'b1;
         end
         OP_STORE32B: begin
            is_store = 1'b1;
            for (int k = 0; k < LANES; k++) begin
               wbyte[k] = q_head.wdata[8*(LANES-1-k) +: 8];
            end
         end
         OP_STORE16: begin
            is_store = 1'b1;
            nbytes   = 3'd2;
            wbyte[0] = q_head.wdata[15:8];
            wbyte[1] = q_head.wdata[7:0];
         end
         OP_STORE8: begin
            is_store = 1'b1;
            nbytes   = 3'd1;
            wbyte[0] = q_head.wdata[7:0] & BYTE_MASK;
         end
         default: begin
            is_store = 1'b0;
         end
      endcase
   end

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [7:0]         mem [LANE_DEPTH];
      logic [7:0]         rdata_ff;
      logic [1:0]         k;
      logic [OFF_W-1:0]   boff;
      logic [LANE_AW-1:0] laddr;
      logic               we;

      assign k     = 2'(l) - q_head.off[1:0];
      assign boff  = q_head.off + OFF_W'(k);
      assign laddr = {bank, boff[OFF_W-1:2]};
      assign we    = q_pop && is_store && !q_head.unmapped &&
                     ({1'b0, k} < nbytes);

      always_ff @(posedge clock) begin
         if (we) begin
            mem[laddr] <= wbyte[k];
         end
         if (q_pop) begin
            rdata_ff <= mem[laddr];
         end
      end

      assign lane_rd[l] = rdata_ff;
   end

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         rbyte[k] = lane_rd[2'(exec_sh_ff + 2'(k))];
      end
      case (exec_op_ff)
         OP_FETCH32: rsp_data_in = {rbyte[3], rbyte[2], rbyte[1], rbyte[0]};
         OP_LOAD32:  rsp_data_in = {rbyte[0], rbyte[1], rbyte[2], rbyte[3]};
         OP_LOAD16:  rsp_data_in = {16'd0, rbyte[0], rbyte[1]};
         OP_LOAD8:   rsp_data_in = {24'd0, rbyte[0]};
         default:    rsp_data_in = '0;
      endcase
      if (exec_unm_ff) begin
         rsp_data_in = '0;
      end
   end

   always_comb begin
      exec_valid_in = exec_valid_ff;
      if (q_pop) begin
         exec_valid_in = 1'b1;
      end else if (exec_adv) begin
         exec_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (exec_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exec_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         exec_valid_ff <= exec_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         exec_op_ff  <= q_head.op;
         exec_unm_ff <= q_head.unmapped;
         exec_hit_ff <= q_head.hit;
         exec_sh_ff  <= q_head.off[1:0];
      end
      if (exec_adv) begin
         rsp_data_ff <= rsp_data_in;
         rsp_unm_ff  <= exec_unm_ff;
         rsp_hit_ff  <= exec_hit_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;
   assign rsp_unmapped  = rsp_unm_ff;
   assign rsp_hit       = rsp_hit_ff;

endmodule
`default_nettype wire

// ===== rtl/region_decoded_memory_access_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// region_decoded_memory_access_unit
// Decodes a bus access against four address regions and performs the load
// or store in the byte bank owned by the matching region.
// ----------------------------------------------------------------------------
// channel   direction  transfer when            contents
// req_      in         req_tvalid & req_tready  operation, address, write_data
// rsp_      out        rsp_tvalid & rsp_tready  read_data, region_hit, unmapped
// csr_      in         csr_we                   region start / size registers
//
// One item per cycle sustained while rsp_tready stays high; an item passes
// decode into the queue, lane memory read, result register, in that order.
// The memory is four byte-lane RAMs with one port each.
// A stalled rsp_ side fills the two-entry queue, then drops req_tready.
// Reset is synchronous and clears the queue, pipeline and region registers;
// memory contents are undefined until written.
// ----------------------------------------------------------------------------
module region_decoded_memory_access_unit
   import rdma_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IX_W-1:0]  csr_index,
   input  wire logic [DATA_W-1:0]    csr_wdata,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [63:0]          req_tdata,  // address, write_data
   input  wire logic [2:0]           req_tuser,  // operation
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [39:0]               rsp_tdata,  // read_data, region_hit, pad
   output logic [0:0]                rsp_tuser   // unmapped
);

   entry_type         entry;
   entry_type         head;
   logic              push;
   logic              not_full;
   logic              not_empty;
   logic              pop;
   logic [DATA_W-1:0] read_data;
   logic              unmapped;
   logic [HIT_W-1:0]  hit;

   rdma_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .op         (op_type'(req_tuser)),
      .address    (req_tdata[31:0]),
      .write_data (req_tdata[63:32]),
      .entry      (entry)
   );

   assign req_tready = not_full;
   assign push       = req_tvalid && not_full;

   rdma_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (entry),
      .not_full   (not_full),
      .pop        (pop),
      .not_empty  (not_empty),
      .head       (head)
   );

   rdma_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_not_empty   (not_empty),
      .q_head        (head),
      .q_pop         (pop),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_read_data (read_data),
      .rsp_unmapped  (unmapped),
      .rsp_hit       (hit)
   );

   assign rsp_tdata = {6'd0, hit, read_data};
   assign rsp_tuser = unmapped;

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the region decoded memory access unit. A table of
// directed accesses covers unmapped addresses, every operation, both byte
// orders, offsets that wrap inside a bank, overlapping regions, a region that
// ends at the top of the address space and a region larger than its bank.
// Random phases then remap the regions and issue loads and stores that only
// read bytes already written. Every response is checked against a local
// model of the decode and the byte banks, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;
   import rdma_pkg::*;

   localparam int CSR_STRIDE      = 2;
   localparam int CSR_START_OFS   = 0;
   localparam int CSR_SIZE_OFS    = 1;
   localparam int SIZE_MAX        = (1 << SIZE_W) - 1;
   localparam int NUM_DIRECTED    = 25;
   localparam int RANDOM_PHASES   = 6;
   localparam int ITEMS_PER_PHASE = 215;
   localparam int LONG_HOLD       = 300;
   localparam int HOLD_AFTER      = 200;
   localparam int DRAIN_PAUSE     = 8;
   localparam int QUIET_LIMIT     = 2000;

   typedef struct packed {
      op_type            op;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] wdata;
   } access_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic              unmapped;
      logic [HIT_W-1:0]  hit;
   } access_result_type;

   typedef struct packed {
      logic              phase;
      op_type            op;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] wdata;
      logic              typed;
      logic [DATA_W-1:0] read_data;
      logic              unmapped;
      logic [HIT_W-1:0]  hit;
   } directed_row_type;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                csr_we     = 1'b0;
   logic [CSR_IX_W-1:0] csr_index  = '0;
   logic [DATA_W-1:0]   csr_wdata  = '0;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [63:0]         req_tdata  = '0;  // address, write_data
   logic [2:0]          req_tuser  = '0;  // operation
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [39:0]         rsp_tdata;        // read_data, region_hit, pad
   logic [0:0]          rsp_tuser;        // unmapped

   logic [ADDR_W-1:0]   region_start [NUM_REGIONS];
   logic [SIZE_W-1:0]   region_size  [NUM_REGIONS];
   logic [7:0]          bank_mem     [NUM_REGIONS*REGION_BYTES];
   bit                  byte_written [NUM_REGIONS*REGION_BYTES];

   access_result_type   pending_results [$];
   int unsigned         fail_count   = 0;
   int unsigned         rsp_count    = 0;
   int unsigned         quiet_cycles = 0;
   bit                  sender_burst = 1'b0;

   directed_row_type directed_rows [NUM_DIRECTED] = '{
      '{1'b0, OP_FETCH32,  32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1, 2'd0},
      '{1'b0, OP_STORE32L, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b1, 2'd0},
      '{1'b0, OP_LOAD8,    32'h1234_5678, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1, 2'd0},
      '{1'b1, OP_STORE32L, 32'h0000_0000, 32'h1122_3344, 1'b1, 32'h0000_0000, 1'b0, 2'd0},
      '{1'b1, OP_FETCH32,  32'h0000_0000, 32'h0000_0000, 1'b1, 32'h1122_3344, 1'b0, 2'd0},
      '{1'b1, OP_LOAD32,   32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'h4433_2211, 1'b0, 2'd0},
      '{1'b1, OP_LOAD16,   32'h0000_0002, 32'h0000_0000, 1'b1, 32'h0000_2211, 1'b0, 2'd0},
      '{1'b1, OP_LOAD8,    32'h0000_0003, 32'h0000_0000, 1'b1, 32'h0000_0011, 1'b0, 2'd0},
      '{1'b1, OP_STORE32B, 32'hFFFF_FFFC, 32'hA1B2_C3D4, 1'b1, 32'h0000_0000, 1'b0, 2'd1},
      '{1'b1, OP_LOAD32,   32'hFFFF_FFFC, 32'h0000_0000, 1'b1, 32'hA1B2_C3D4, 1'b0, 2'd1},
      '{1'b1, OP_FETCH32,  32'hFFFF_FFFC, 32'h0000_0000, 1'b1, 32'hD4C3_B2A1, 1'b0, 2'd1},
      '{1'b1, OP_STORE16,  32'hFFFF_FFFF, 32'hFFFF_5566, 1'b1, 32'h0000_0000, 1'b0, 2'd1},
      '{1'b1, OP_LOAD16,   32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0, 2'd0},
      '{1'b1, OP_STORE8,   32'h0000_0FFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b0, 2'd0},
      '{1'b1, OP_STORE32L, 32'h0000_0FFE, 32'hCAFE_F00D, 1'b0, 32'h0000_0000, 1'b0, 2'd0},
      '{1'b1, OP_LOAD32,   32'h0000_0FFE, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0, 2'd0},
      '{1'b1, OP_STORE8,   32'h0000_0800, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0, 2'd0},
      '{1'b1, OP_LOAD8,    32'h0000_0800, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0, 2'd0},
      '{1'b1, OP_STORE32L, 32'h8000_1000, 32'h00C0_FFEE, 1'b1, 32'h0000_0000, 1'b0, 2'd3},
      '{1'b1, OP_LOAD32,   32'h8000_0000, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0, 2'd0},
      '{1'b1, OP_STORE8,   32'h8000_1FFE, 32'h0000_00A5, 1'b1, 32'h0000_0000, 1'b0, 2'd3},
      '{1'b1, OP_LOAD8,    32'h8000_1FFE, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0, 2'd0},
      '{1'b1, OP_LOAD8,    32'h8000_1FFF, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1, 2'd0},
      '{1'b1, OP_FETCH32,  32'h0000_1000, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1, 2'd0},
      '{1'b1, OP_LOAD32,   32'hFFFF_EFFF, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1, 2'd0}
   };

   region_decoded_memory_access_unit dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned pick_idle_len(input bit burst);
      int unsigned p;
      p = $urandom_range(0, 99);
      if (burst || p < 55) return 0;
      if (p < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // lowest index wins; the region end is formed without wrap
   function automatic bit locate_region(input logic [ADDR_W-1:0] addr,
                                        output logic [HIT_W-1:0] hit);
      logic [ADDR_W:0] lim;
      hit = '0;
      for (int i = 0; i < NUM_REGIONS; i++) begin
         lim = {1'b0, region_start[i]} + (ADDR_W+1)'(region_size[i]);
         if (addr >= region_start[i] && {1'b0, addr} < lim) begin
            hit = HIT_W'(i);
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic int unsigned byte_slot(input logic [HIT_W-1:0] bank,
                                             input int unsigned off, input int unsigned k);
      return int'(bank) * REGION_BYTES + (off + k) % REGION_BYTES;
   endfunction

   function automatic logic [7:0] get_byte(input logic [HIT_W-1:0] bank,
                                           input int unsigned off, input int unsigned k);
      return bank_mem[byte_slot(bank, off, k)];
   endfunction

   function automatic void put_byte(input logic [HIT_W-1:0] bank, input int unsigned off,
                                    input int unsigned k, input logic [7:0] v);
      bank_mem[byte_slot(bank, off, k)]     = v;
      byte_written[byte_slot(bank, off, k)] = 1'b1;
   endfunction

   function automatic access_result_type perform_access(input access_type a);
      access_result_type r;
      logic [HIT_W-1:0] bank;
      int unsigned off;
      r = '0;
      if (!locate_region(a.addr, bank)) begin
         r.unmapped = 1'b1;
         return r;
      end
      r.hit = bank;
      off = a.addr - region_start[bank];
      case (a.op)
         OP_FETCH32: r.read_data = {get_byte(bank, off, 3), get_byte(bank, off, 2),
                                    get_byte(bank, off, 1), get_byte(bank, off, 0)};
         OP_LOAD32:  r.read_data = {get_byte(bank, off, 0), get_byte(bank, off, 1),
                                    get_byte(bank, off, 2), get_byte(bank, off, 3)};
         OP_LOAD16:  r.read_data = {16'h0, get_byte(bank, off, 0), get_byte(bank, off, 1)};
         OP_LOAD8:   r.read_data = {24'h0, get_byte(bank, off, 0)};
         OP_STORE32L: begin
            put_byte(bank, off, 0, a.wdata[7:0]);
            put_byte(bank, off, 1, a.wdata[15:8]);
            put_byte(bank, off, 2, a.wdata[23:16]);
            put_byte(bank, off, 3, a.wdata[31:24]);
         end
         OP_STORE32B: begin
            put_byte(bank, off, 0, a.wdata[31:24]);
            put_byte(bank, off, 1, a.wdata[23:16]);
            put_byte(bank, off, 2, a.wdata[15:8]);
            put_byte(bank, off, 3, a.wdata[7:0]);
         end
         OP_STORE16: begin
            put_byte(bank, off, 0, a.wdata[15:8]);
            put_byte(bank, off, 1, a.wdata[7:0]);
         end
         default: put_byte(bank, off, 0, a.wdata[7:0]);
      endcase
      return r;
   endfunction

   function automatic bit reads_only_written(input access_type a);
      logic [HIT_W-1:0] bank;
      int unsigned off, n;
      if (a.op inside {OP_STORE32L, OP_STORE32B, OP_STORE16, OP_STORE8}) return 1'b1;
      if (!locate_region(a.addr, bank)) return 1'b1;
      n = (a.op == OP_LOAD8) ? 1 : (a.op == OP_LOAD16) ? 2 : 4;
      off = a.addr - region_start[bank];
      for (int unsigned k = 0; k < n; k++)
         if (!byte_written[byte_slot(bank, off, k)]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic access_type random_access();
      access_type a;
      int unsigned r, sz, off, p;
      a.op    = op_type'($urandom_range(OP_FETCH32, OP_STORE8));
      a.wdata = $urandom();
      a.addr  = $urandom();
      r  = $urandom_range(0, NUM_REGIONS - 1);
      sz = region_size[r];
      p  = $urandom_range(0, 99);
      if (p >= 10 && sz != 0) begin
         p = $urandom_range(0, 99);
         if (sz <= 64 || p >= 80) off = $urandom_range(0, sz - 1);
         else if (p < 65) off = $urandom_range(0, 63);
         else off = $urandom_range(sz - 4, sz - 1);
         a.addr = region_start[r] + off;
      end
      // a load that would touch a never written byte becomes the matching store
      if (!reads_only_written(a)) begin
         case (a.op)
            OP_FETCH32: a.op = OP_STORE32L;
            OP_LOAD32:  a.op = OP_STORE32B;
            OP_LOAD16:  a.op = OP_STORE16;
            default:    a.op = OP_STORE8;
         endcase
      end
      return a;
   endfunction

   task automatic program_region_map(input logic [NUM_REGIONS-1:0][31:0] starts,
                                     input logic [NUM_REGIONS-1:0][31:0] sizes);
      csr_we <= 1'b1;
      for (int r = 0; r < NUM_REGIONS; r++) begin
         csr_index <= CSR_IX_W'(r * CSR_STRIDE + CSR_START_OFS);
         csr_wdata <= starts[r];
         @(posedge clock);
         csr_index <= CSR_IX_W'(r * CSR_STRIDE + CSR_SIZE_OFS);
         csr_wdata <= sizes[r];
         @(posedge clock);
         region_start[r] = starts[r];
         region_size[r]  = sizes[r][SIZE_W-1:0];
      end
      csr_we <= 1'b0;
   endtask

   task automatic randomize_region_map();
      logic [NUM_REGIONS-1:0][31:0] starts, sizes;
      int unsigned p;
      for (int r = 0; r < NUM_REGIONS; r++) begin
         p = $urandom_range(0, 99);
         if (p < 8) sizes[r] = 0;
         else if (p < 16) sizes[r] = 1;
         else if (p < 56) sizes[r] = $urandom_range(2, 64);
         else if (p < 78) sizes[r] = $urandom_range(65, 512);
         else if (p < 93) sizes[r] = REGION_BYTES;
         else sizes[r] = $urandom_range(REGION_BYTES + 1, SIZE_MAX);
         p = $urandom_range(0, 99);
         if (p < 10) starts[r] = 32'h0;
         else if (p < 20) starts[r] = 32'h0 - sizes[r];
         else if (p < 25) starts[r] = 32'hFFFF_FFFF;
         else if (p < 45 && r > 0) starts[r] = starts[$urandom_range(0, r - 1)]
                                               + $urandom_range(0, 32);
         else starts[r] = $urandom();
      end
      program_region_map(starts, sizes);
   endtask

   task automatic send_access(input access_type a, input bit typed,
                              input access_result_type typed_result);
      int unsigned gap;
      bit ready;
      access_result_type want;
      gap = pick_idle_len(sender_burst);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {a.wdata, a.addr};
      req_tuser  <= a.op;
      do begin
         @(negedge clock);
         ready = req_tready;
         @(posedge clock);
      end while (!ready);
      want = perform_access(a);
      pending_results.push_back(typed ? typed_result : want);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_PAUSE) @(posedge clock);
   endtask

   initial begin : stimulus
      directed_row_type row;
      access_type acc;
      access_result_type res;
      logic cur_phase;
      logic [NUM_REGIONS-1:0][31:0] dir_starts, dir_sizes;
      for (int r = 0; r < NUM_REGIONS; r++) begin
         region_start[r] = '0;
         region_size[r]  = '0;
      end
      // region 2 sits inside region 0, region 1 ends at the top of the space,
      // region 3 is larger than its bank
      dir_starts[0] = 32'h0000_0000;  dir_sizes[0] = REGION_BYTES;
      dir_starts[1] = 32'hFFFF_F000;  dir_sizes[1] = REGION_BYTES;
      dir_starts[2] = 32'h0000_0800;  dir_sizes[2] = 64;
      dir_starts[3] = 32'h8000_0000;  dir_sizes[3] = SIZE_MAX;
      cur_phase = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_DIRECTED; i++) begin
         row = directed_rows[i];
         if (row.phase != cur_phase) begin
            wait_drained();
            program_region_map(dir_starts, dir_sizes);
            cur_phase = row.phase;
         end
         acc = '{row.op, row.addr, row.wdata};
         res = '{row.read_data, row.unmapped, row.hit};
         send_access(acc, row.typed, res);
      end

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         wait_drained();
         randomize_region_map();
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (n % 50 == 0) sender_burst = ($urandom_range(0, 3) == 0);
            send_access(random_access(), 1'b0, '0);
         end
      end

      wait_drained();
      if (fail_count == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

   initial begin : rsp_sink
      int unsigned run, gap;
      bit burst, long_hold_done;
      long_hold_done = 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         burst = ($urandom_range(0, 3) == 0);
         repeat (8) begin
            rsp_tready <= 1'b1;
            run = $urandom_range(1, 12);
            repeat (run) @(posedge clock);
            if (!long_hold_done && rsp_count >= HOLD_AFTER) begin
               long_hold_done = 1'b1;
               gap = LONG_HOLD;
            end else begin
               gap = pick_idle_len(burst);
            end
            if (gap != 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   end

   // transfers are sampled at the falling edge before the edge that takes them
   always @(negedge clock) begin : rsp_check
      access_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.read_data = rsp_tdata[31:0];
         got.hit       = rsp_tdata[33:32];
         got.unmapped  = rsp_tuser[0];
         rsp_count++;
         if (pending_results.size() == 0) begin
            $error("response transfer with nothing outstanding");
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (got.read_data !== want.read_data) begin
               $error("read_data: expected %h, got %h", want.read_data, got.read_data);
               fail_count++;
            end
            if (got.unmapped !== want.unmapped) begin
               $error("unmapped: expected %b, got %b", want.unmapped, got.unmapped);
               fail_count++;
            end
            if (got.hit !== want.hit) begin
               $error("region_hit: expected %0d, got %0d", want.hit, got.hit);
               fail_count++;
            end
         end
      end
   end

   always @(negedge clock) begin : watchdog
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

endmodule
